// ===== design/assert_macros.svh =====
// Assertion helpers shared by the design files.
// Each helper samples on the rising edge of clk and is switched off while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every sampled edge.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// The condition must never be true at a sampled edge.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== design/suf_pkg.sv =====
package suf_pkg;

  // Longest run of bytes that offsets are meant to count.
  localparam int MAX_BYTES = 65536;
  // Offsets and character indexes saturate at this value.
  localparam logic [15:0] POS_LIMIT =
    ((MAX_BYTES - 1) > 65535) ? 16'hFFFF : 16'(MAX_BYTES - 1);

  // Result kinds.
  localparam logic [1:0] KIND_CP  = 2'd0;
  localparam logic [1:0] KIND_ERR = 2'd1;
  localparam logic [1:0] KIND_END = 2'd2;

  // Queue between the decoding front and the result back.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // One queue entry holds everything a byte causes: an optional character
  // result and, on the final byte, the end-of-input marker.
  typedef struct packed {
    logic        has_char;
    logic [1:0]  kind;
    logic [20:0] code_point;
    logic [15:0] start_offset;
    logic [15:0] char_position;
    logic        fin;
  } entry_t;

endpackage

// ===== design/suf_front.sv =====
module suf_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      data_byte,
  input  logic            final_byte,
  input  logic            q_full,
  output logic            push,
  output suf_pkg::entry_t entry
);

  logic [1:0]  pending, pending_next;
  logic [1:0]  seq_len, seq_len_next;
  logic [20:0] partial, partial_next;
  logic        bad, bad_next;
  logic [15:0] byte_count, byte_count_next;
  logic [15:0] char_start, char_start_next;
  logic [15:0] char_count, char_count_next;
  logic        done;
  logic        value_ok;
  logic        accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    pending_next    = pending;
    seq_len_next    = seq_len;
    partial_next    = partial;
    bad_next        = bad;
    char_start_next = char_start;
    char_count_next = char_count;
    if (pending == 2'd0) begin
      if (byte_count != 16'd0 && char_count < suf_pkg::POS_LIMIT) begin
        char_count_next = char_count + 16'd1;
      end
      char_start_next = byte_count;
      bad_next        = 1'b0;
      if (data_byte[7] == 1'b0) begin
        seq_len_next = 2'd0;
        partial_next = {13'd0, data_byte};
      end else if (data_byte[7:5] == 3'b110) begin
        seq_len_next = 2'd1;
        partial_next = {16'd0, data_byte[4:0]};
      end else if (data_byte[7:4] == 4'b1110) begin
        seq_len_next = 2'd2;
        partial_next = {17'd0, data_byte[3:0]};
      end else if (data_byte[7:3] == 5'b11110) begin
        seq_len_next = 2'd3;
        partial_next = {18'd0, data_byte[2:0]};
      end else begin
        // Stray continuation byte or a lead byte of the form 11111xxx.
        seq_len_next = 2'd0;
        partial_next = 21'd0;
        bad_next     = 1'b1;
      end
      pending_next = seq_len_next;
    end else begin
      if (data_byte[7:6] != 2'b10) begin
        bad_next = 1'b1;
      end
      partial_next = {partial[14:0], data_byte[5:0]};
      pending_next = pending - 2'd1;
    end
    done = (pending_next == 2'd0);

    byte_count_next = (byte_count < suf_pkg::POS_LIMIT) ? byte_count + 16'd1 : byte_count;

    unique case (seq_len_next)
      2'd0: value_ok = (partial_next < 21'd128);
      2'd1: value_ok = (partial_next >= 21'd128) && (partial_next <= 21'd2047);
      2'd2: value_ok = (partial_next >= 21'd2048) && (partial_next <= 21'd65535) &&
                       ((partial_next < 21'd55296) || (partial_next > 21'd57343));
      default: value_ok = (partial_next >= 21'd65536) && (partial_next <= 21'd1114111);
    endcase
  end

  always_comb begin
    entry.has_char      = done || final_byte;
    entry.kind          = (done && !bad_next && value_ok) ? suf_pkg::KIND_CP
                                                          : suf_pkg::KIND_ERR;
    entry.code_point    = (done && !bad_next && value_ok) ? partial_next : 21'd0;
    entry.start_offset  = char_start_next;
    entry.char_position = char_count_next;
    entry.fin           = final_byte;
  end

  assign push = accept && (done || final_byte);

  always_ff @(posedge clk) begin
    if (rst || (accept && final_byte)) begin
      pending    <= 2'd0;
      seq_len    <= 2'd0;
      partial    <= 21'd0;
      bad        <= 1'b0;
      byte_count <= 16'd0;
      char_start <= 16'd0;
      char_count <= 16'd0;
    end else if (accept) begin
      pending    <= pending_next;
      seq_len    <= seq_len_next;
      partial    <= partial_next;
      bad        <= bad_next;
      byte_count <= byte_count_next;
      char_start <= char_start_next;
      char_count <= char_count_next;
    end
  end

endmodule

// ===== design/suf_fifo.sv =====
module suf_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  suf_pkg::entry_t wr_entry,
  output logic            full,
  input  logic            pop,
  output suf_pkg::entry_t rd_entry,
  output logic            empty
);

  suf_pkg::entry_t               slots [suf_pkg::QDEPTH];
  logic [suf_pkg::QPTR_W-1:0]    wr_ptr;
  logic [suf_pkg::QPTR_W-1:0]    rd_ptr;
  logic [suf_pkg::QCNT_W-1:0]    count;

  assign full     = (count == suf_pkg::QCNT_W'(suf_pkg::QDEPTH));
  assign empty    = (count == '0);
  assign rd_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== design/suf_back.sv =====
module suf_back (
  input  logic            clk,
  input  logic            rst,
  input  suf_pkg::entry_t head,
  input  logic            q_empty,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [1:0]      result_kind,
  output logic [20:0]     code_point,
  output logic [15:0]     start_offset,
  output logic [15:0]     char_position,
  output logic            run_end
);

  // Set while the end marker of an entry whose character went out is still owed.
  logic phase;
  logic load;
  logic emit_end;
  logic last_of_entry;

  assign load          = !out_valid || out_ready;
  assign emit_end      = phase || !head.has_char;
  assign last_of_entry = phase || !(head.has_char && head.fin);
  assign pop           = load && !q_empty && last_of_entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= 1'b0;
    end else if (load) begin
      out_valid <= !q_empty;
      if (!q_empty) begin
        phase <= !last_of_entry;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && !q_empty) begin
      result_kind   <= emit_end ? suf_pkg::KIND_END : head.kind;
      code_point    <= emit_end ? 21'd0 : head.code_point;
      start_offset  <= head.start_offset;
      char_position <= head.char_position;
      run_end       <= emit_end || !head.fin;
    end
  end

endmodule

// ===== design/strict_utf8_decoder_unit.sv =====
// Strict UTF-8 decoder. One byte enters per transfer on the s_ side, with s_tlast marking
// the last byte of the input; results leave on the m_ side as transfers of kind code point,
// decoding error or end of input, each tagged with the byte offset where its character
// began and the character index (both saturate at 65535). A lead byte fixes how many
// following bytes are consumed, whatever they hold; a character yields one result when its
// last byte arrives, and a byte in the middle of a character yields none. Overlong forms,
// surrogates, values above 0x10FFFF, stray continuation bytes and 11111xxx lead bytes are
// errors. On the final byte a cut-short character gives an error and then an end result
// with m_tlast high, after which offsets and indexes restart at zero. The input takes one
// byte per cycle while s_tready is high: the decoding front updates its state once per
// byte and writes at most one entry per byte into a four-entry queue. The result side
// emits one transfer per cycle while m_tready is high, so a final byte, which always
// yields a character or an error before its end result, occupies it for two transfers.
// On its way out a result is written into a queue entry when its byte is taken and then
// moves into the output register once that register is free. With m_tready low the output
// register and then the four queue entries fill, and s_tready drops once the queue is full.
module strict_utf8_decoder_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // final_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  // [1:0] result_kind, [22:2] code_point, [38:23] start_offset,
  // [54:39] char_position, [55] zero
  output logic [55:0] m_tdata,
  output logic        m_tlast    // run_end
);

  `include "assert_macros.svh"

  logic            push;
  logic            pop;
  logic            q_full;
  logic            q_empty;
  suf_pkg::entry_t wr_entry;
  suf_pkg::entry_t head;
  logic [1:0]      result_kind;
  logic [20:0]     code_point;
  logic [15:0]     start_offset;
  logic [15:0]     char_position;

  // Front: tracks the sequence state and classifies every byte.
  suf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .data_byte  (s_tdata),
    .final_byte (s_tlast),
    .q_full     (q_full),
    .push       (push),
    .entry      (wr_entry)
  );

  // Queue that lets input and output stall independently.
  suf_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (wr_entry),
    .full     (q_full),
    .pop      (pop),
    .rd_entry (head),
    .empty    (q_empty)
  );

  // Back: turns each entry into one or two result transfers.
  suf_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .q_empty       (q_empty),
    .pop           (pop),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .result_kind   (result_kind),
    .code_point    (code_point),
    .start_offset  (start_offset),
    .char_position (char_position),
    .run_end       (m_tlast)
  );

  assign m_tdata = {1'b0, char_position, start_offset, code_point, result_kind};

  // Only a decoded character carries a value.
  `ASSERT_CLK(a_cp_zero_unless_char,
    (m_tvalid && (result_kind != suf_pkg::KIND_CP)) |-> (code_point == 21'd0),
    "code point set on a non-character result")

  // Every end result closes the run.
  `ASSERT_CLK(a_end_has_last,
    (m_tvalid && (result_kind == suf_pkg::KIND_END)) |-> m_tlast,
    "end result without run_end")

  // A decoded value is always a Unicode scalar value.
  `ASSERT_NEVER(a_cp_scalar,
    m_tvalid && (result_kind == suf_pkg::KIND_CP) &&
      (((code_point >= 21'd55296) && (code_point <= 21'd57343)) ||
       (code_point > 21'd1114111)),
    "decoded value is a surrogate or out of range")

endmodule

// ===== tb/tb_strict_utf8_decoder_unit.sv =====
`timescale 1ns / 1ps

module tb_strict_utf8_decoder_unit;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 10;
  localparam int CYCLE_LIMIT  = 100_000;
  localparam int LONG_HOLD    = 300;
  localparam int SETTLE       = 8;
  localparam int MAX_PRINTS   = 20;

  // One expected result, fields as they leave the block.
  typedef struct packed {
    logic [1:0]  kind;
    logic [20:0] code_point;
    logic [15:0] start_offset;
    logic [15:0] char_position;
    logic        run_end;
  } decoded_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;   // [7:0] data_byte
  logic        s_tlast = 1'b0;   // final_byte
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // [1:0] result_kind, [22:2] code_point, [38:23] start_offset,
  // [54:39] char_position, [55] zero
  logic [55:0] m_tdata;
  logic        m_tlast;          // run_end

  // Decoder state as the testbench tracks it.
  logic [1:0]  cont_left   = '0;
  logic [1:0]  cont_total  = '0;
  logic [20:0] cp_accum    = '0;
  logic        seq_broken  = 1'b0;
  logic [15:0] byte_pos    = '0;
  logic [15:0] char_origin = '0;
  logic [15:0] char_index  = '0;

  decoded_result_t pending_results[$];

  int  cycle_count    = 0;
  int  mismatch_count = 0;
  int  bytes_sent     = 0;
  int  cp_seen        = 0;
  int  err_seen       = 0;
  int  end_seen       = 0;
  int  hold_left      = 0;
  bit  hold_request   = 1'b0;
  bit  quiet          = 1'b0;

  strict_utf8_decoder_unit uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #CLK_HALF clk = ~clk;

  function automatic bit scalar_in_range(input logic [1:0] len, input logic [20:0] v);
    case (len)
      2'd0:    return v < 21'd128;
      2'd1:    return v >= 21'd128 && v <= 21'd2047;
      2'd2:    return v >= 21'd2048 && v <= 21'd65535 && (v < 21'd55296 || v > 21'd57343);
      default: return v >= 21'd65536 && v <= 21'd1114111;
    endcase
  endfunction

  function automatic void push_expected(input logic [1:0] kind, input logic [20:0] cp,
                                        input logic last);
    decoded_result_t r;
    r.kind          = kind;
    r.code_point    = (kind == suf_pkg::KIND_CP) ? cp : '0;
    r.start_offset  = char_origin;
    r.char_position = char_index;
    r.run_end       = last;
    pending_results.push_back(r);
  endfunction

  // Advances the tracked decoder by one accepted byte and queues what it causes.
  function automatic void decode_byte(input logic [7:0] b, input logic fin);
    logic done;
    if (cont_left == 2'd0) begin
      if (byte_pos != 16'd0 && char_index < suf_pkg::POS_LIMIT) char_index++;
      char_origin = byte_pos;
      seq_broken  = 1'b0;
      if (b[7] == 1'b0) begin
        cont_total = 2'd0;
        cp_accum   = {14'd0, b[6:0]};
      end else if (b[7:5] == 3'b110) begin
        cont_total = 2'd1;
        cp_accum   = {16'd0, b[4:0]};
      end else if (b[7:4] == 4'b1110) begin
        cont_total = 2'd2;
        cp_accum   = {17'd0, b[3:0]};
      end else if (b[7:3] == 5'b11110) begin
        cont_total = 2'd3;
        cp_accum   = {18'd0, b[2:0]};
      end else begin
        // Stray continuation byte or 11111xxx lead: a one-byte error.
        cont_total = 2'd0;
        cp_accum   = '0;
        seq_broken = 1'b1;
      end
      cont_left = cont_total;
      done      = (cont_left == 2'd0);
    end else begin
      // Any byte is consumed here; a non-continuation byte spoils the sequence.
      if (b[7:6] != 2'b10) seq_broken = 1'b1;
      cp_accum  = {cp_accum[14:0], b[5:0]};
      cont_left = cont_left - 2'd1;
      done      = (cont_left == 2'd0);
    end
    if (byte_pos < suf_pkg::POS_LIMIT) byte_pos++;

    if (done) begin
      if (!seq_broken && scalar_in_range(cont_total, cp_accum))
        push_expected(suf_pkg::KIND_CP, cp_accum, !fin);
      else
        push_expected(suf_pkg::KIND_ERR, '0, !fin);
    end else if (fin) begin
      push_expected(suf_pkg::KIND_ERR, '0, 1'b0);
    end

    if (fin) begin
      push_expected(suf_pkg::KIND_END, '0, 1'b1);
      cont_left   = '0;
      cont_total  = '0;
      cp_accum    = '0;
      seq_broken  = 1'b0;
      byte_pos    = '0;
      char_origin = '0;
      char_index  = '0;
    end
  endfunction

  function automatic int natural_len(input logic [20:0] cp);
    if (cp < 21'h80) return 0;
    if (cp < 21'h800) return 1;
    if (cp < 21'h10000) return 2;
    return 3;
  endfunction

  // Encodes cp with len continuation bytes; first byte in the low bits.
  function automatic logic [31:0] utf8_bytes(input logic [20:0] cp, input int len);
    case (len)
      0:       return {24'd0, 1'b0, cp[6:0]};
      1:       return {16'd0, 2'b10, cp[5:0], 3'b110, cp[10:6]};
      2:       return {8'd0, 2'b10, cp[5:0], 2'b10, cp[11:6], 4'b1110, cp[15:12]};
      default: return {2'b10, cp[5:0], 2'b10, cp[11:6], 2'b10, cp[17:12],
                       5'b11110, cp[20:18]};
    endcase
  endfunction

  function automatic logic [20:0] boundary_cp(input int i);
    case (i)
      0:       return 21'h0;
      1:       return 21'h7F;
      2:       return 21'h80;
      3:       return 21'h7FF;
      4:       return 21'h800;
      5:       return 21'hD7FF;
      6:       return 21'hE000;
      7:       return 21'hFFFF;
      8:       return 21'h10000;
      default: return 21'h10FFFF;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS)
      $display("MISMATCH %s: got 0x%0h, expected 0x%0h (cycle %0d)",
               what, got, want, cycle_count);
  endtask

  // Compares one accepted result transfer with the oldest expectation.
  task automatic check_result;
    decoded_result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("result with nothing expected", m_tdata[31:0], 32'd0);
    end else begin
      want = pending_results.pop_front();
      if (m_tdata[1:0] != want.kind)
        report_mismatch("result_kind", 32'(m_tdata[1:0]), 32'(want.kind));
      if (m_tdata[22:2] != want.code_point)
        report_mismatch("code_point", 32'(m_tdata[22:2]), 32'(want.code_point));
      if (m_tdata[38:23] != want.start_offset)
        report_mismatch("start_offset", 32'(m_tdata[38:23]), 32'(want.start_offset));
      if (m_tdata[54:39] != want.char_position)
        report_mismatch("char_position", 32'(m_tdata[54:39]), 32'(want.char_position));
      if (m_tdata[55] != 1'b0)
        report_mismatch("tdata padding", 32'(m_tdata[55]), 32'd0);
      if (m_tlast != want.run_end)
        report_mismatch("run_end", 32'(m_tlast), 32'(want.run_end));
      if (want.kind == suf_pkg::KIND_CP) cp_seen++;
      else if (want.kind == suf_pkg::KIND_ERR) err_seen++;
      else end_seen++;
    end
  endtask

  // Result side: checks each transfer, then picks tready for the next cycle.
  // A requested hold is counted out here, independent of the sender.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) check_result();
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = LONG_HOLD;
        m_tready    <= 1'b0;
      end else begin
        m_tready <= quiet || ($urandom_range(0, 99) >= 12);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // Offers one byte, possibly after a one-cycle gap, and waits for its transfer.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 99) < 12) gap = 1;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= fin;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    decode_byte(b, fin);
    bytes_sent++;
  endtask

  task automatic send_char(input logic [20:0] cp, input int len, input bit fin);
    logic [31:0] seq;
    int k;
    seq = utf8_bytes(cp, len);
    for (k = 0; k <= len; k++) send_byte(seq[8*k +: 8], fin && (k == len));
  endtask

  // Stops offering, waits for every expected result, and then lets the block settle.
  task automatic wait_drain;
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic test_valid_forms;
    send_char(21'h0, 0, 1'b0);
    send_char(21'h7F, 0, 1'b0);
    send_char(21'h80, 1, 1'b0);
    send_char(21'hFFFF, 2, 1'b0);
    send_char(21'h10FFFF, 3, 1'b0);
    wait_drain();
  endtask

  task automatic test_error_forms;
    send_char(21'h7F, 1, 1'b0);       // overlong two-byte form
    send_char(21'hD800, 2, 1'b0);     // surrogate
    send_char(21'h110000, 3, 1'b0);   // above the Unicode range
    send_byte(8'h80, 1'b0);           // stray continuation
    send_byte(8'hFF, 1'b0);           // 11111xxx lead
    send_byte(8'hC3, 1'b0);           // lead, then a plain letter is swallowed
    send_byte(8'h41, 1'b0);
    wait_drain();
  endtask

  task automatic test_final_byte;
    // Cut short by the final flag: error, then end of input.
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b1);
    // A complete character on the final byte, then a fresh run after it.
    send_char(21'h41, 0, 1'b1);
    send_char(21'h20AC, 2, 1'b0);
    send_byte(8'hF0, 1'b1);
    wait_drain();
  endtask

  // Result side holds off for a long time while bytes keep coming, so the
  // block's queue fills and its input stalls.
  task automatic test_output_hold;
    int k;
    quiet        = 1'b1;
    hold_request = 1'b1;
    for (k = 0; k < 40; k++) send_byte(8'($urandom_range(0, 127)), 1'b0);
    quiet = 1'b0;
    wait_drain();
  endtask

  // Mostly well-formed characters with random content, plus corrupted and
  // truncated sequences, raw noise and random final flags.
  task automatic test_random_stream(input int n_bytes);
    int          first;
    int          pick;
    int          len;
    int          k;
    logic [20:0] cp;
    logic [31:0] seq;
    first = bytes_sent;
    while (bytes_sent - first < n_bytes) begin
      if ($urandom_range(0, 99) < 15) begin
        send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 99) < 3);
      end else begin
        pick = $urandom_range(0, 9);
        case (pick)
          0:       cp = 21'($urandom_range(0, 127));
          1:       cp = 21'($urandom_range(128, 2047));
          2:       cp = 21'($urandom_range(2048, 65535));
          3:       cp = 21'($urandom_range(65536, 1114111));
          4:       cp = boundary_cp($urandom_range(0, 9));
          5:       cp = 21'($urandom_range(55296, 57343));
          6:       cp = 21'($urandom_range(1114112, 2097151));
          7:       cp = 21'($urandom_range(0, 65535));
          default: cp = 21'($urandom_range(0, 1114111));
        endcase
        len = natural_len(cp);
        // Overlong: more continuation bytes than the value needs.
        if (pick == 7 && len < 3) len = $urandom_range(len + 1, 3);
        seq = utf8_bytes(cp, len);
        if (len > 0 && $urandom_range(0, 99) < 10) begin
          if ($urandom_range(0, 1) == 1)
            seq[8*$urandom_range(1, len) +: 8] = 8'($urandom_range(0, 255));
          else
            len = $urandom_range(0, len - 1);
        end
        for (k = 0; k <= len; k++)
          send_byte(seq[8*k +: 8], $urandom_range(0, 99) < ((k == len) ? 5 : 1));
      end
      if ($urandom_range(0, 49) == 0) wait_drain();
    end
    wait_drain();
  endtask

  // One long run without idling on either side, mostly single-byte characters
  // so that results leave as fast as bytes arrive.
  task automatic test_no_idle(input int n_bytes);
    int          first;
    logic [20:0] cp;
    quiet = 1'b1;
    first = bytes_sent;
    while (bytes_sent - first < n_bytes) begin
      if ($urandom_range(0, 99) < 70) begin
        send_char(21'($urandom_range(0, 127)), 0, 1'b0);
      end else begin
        cp = 21'($urandom_range(128, 1114111));
        if (cp >= 21'd55296 && cp <= 21'd57343) cp = 21'hE000;
        send_char(cp, natural_len(cp), 1'b0);
      end
    end
    send_char(21'h1F600, 3, 1'b1);
    quiet = 1'b0;
    wait_drain();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    test_valid_forms();
    test_error_forms();
    test_final_byte();
    test_output_hold();
    test_random_stream(600);
    test_no_idle(200);
    test_random_stream(150);
    $display("Sent %0d bytes; checked %0d code points, %0d errors and %0d run ends.",
             bytes_sent, cp_seen, err_seen, end_seen);
    $display("Covered every error form, truncated runs, a long output hold and %s",
             "a stretch with no idling on either side.");
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/suf_pkg.sv
design/suf_front.sv
design/suf_fifo.sv
design/suf_back.sv
design/strict_utf8_decoder_unit.sv
tb/tb_strict_utf8_decoder_unit.sv
